// ----- hdl/pidaw_pkg.sv -----
// pidaw_pkg: shared types and constants for the PID drive block.
// No dependencies; imported by every module of the block.
package pidaw_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SETPOINT    = 3'd0,
    CFG_P_GAIN      = 3'd1,
    CFG_I_GAIN      = 3'd2,
    CFG_D_GAIN      = 3'd3,
    CFG_DRIVE_LIMIT = 3'd4
  } cfg_idx_t;

  // Reset values, sliced to the configured widths by the register file
  localparam logic [31:0] RST_SETPOINT    = 32'd150;
  localparam logic [31:0] RST_P_GAIN      = 32'd256;
  localparam logic [31:0] RST_I_GAIN      = 32'd128;
  localparam logic [31:0] RST_D_GAIN      = 32'd0;
  localparam logic [31:0] RST_DRIVE_LIMIT = 32'd2700;

  // Per-stage pipeline control: global advance plus the stage's incoming valid
  typedef struct packed {
    logic adv;
    logic vld;
  } stage_ctl_t;

endpackage

// ----- hdl/pidaw_if.sv -----
// pidaw_in_if / pidaw_out_if: valid/ready channels of the PID drive block.
// No dependencies.
interface pidaw_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] feedback;

  modport source (output valid, output feedback, input ready);
  modport sink   (input valid, input feedback, output ready);
endinterface

interface pidaw_out_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                        valid;
  logic                        ready;
  logic [SAMPLE_BITS-1:0]      drive;
  logic signed [SAMPLE_BITS:0] error_value;

  modport source (output valid, output drive, output error_value, input ready);
  modport sink   (input valid, input drive, input error_value, output ready);
endinterface

// ----- hdl/pidaw_cfg.sv -----
// pidaw_cfg: configuration register file (setpoint, gains, drive limit).
// Depends on pidaw_pkg.
module pidaw_cfg #(
  parameter int S = 12,
  parameter int F = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pidaw_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [S+F-1:0]                       cfg_data,
  output logic [S-1:0]                         setpoint,
  output logic [S+F-1:0]                       p_gain,
  output logic [S+F-1:0]                       i_gain,
  output logic [S+F-1:0]                       d_gain,
  output logic [S-1:0]                         drive_limit
);
  import pidaw_pkg::*;

  localparam int G = S + F;

  logic [S-1:0] setpoint_r;
  logic [G-1:0] p_gain_r;
  logic [G-1:0] i_gain_r;
  logic [G-1:0] d_gain_r;
  logic [S-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= RST_SETPOINT[S-1:0];
      p_gain_r   <= RST_P_GAIN[G-1:0];
      i_gain_r   <= RST_I_GAIN[G-1:0];
      d_gain_r   <= RST_D_GAIN[G-1:0];
      limit_r    <= RST_DRIVE_LIMIT[S-1:0];
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SETPOINT:    setpoint_r <= cfg_data[S-1:0];
        CFG_P_GAIN:      p_gain_r   <= cfg_data;
        CFG_I_GAIN:      i_gain_r   <= cfg_data;
        CFG_D_GAIN:      d_gain_r   <= cfg_data;
        CFG_DRIVE_LIMIT: limit_r    <= cfg_data[S-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  assign setpoint    = setpoint_r;
  assign p_gain      = p_gain_r;
  assign i_gain      = i_gain_r;
  assign d_gain      = d_gain_r;
  assign drive_limit = limit_r;

endmodule

// ----- hdl/pidaw_mult.sv -----
// pidaw_mult: sample register, error, error delta and the three gain products.
// Depends on pidaw_pkg.
module pidaw_mult #(
  parameter int S = 12,
  parameter int F = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pidaw_pkg::stage_ctl_t           ctl,       // vld = input item accepted
  input  logic [S-1:0]                    feedback,
  input  logic [S-1:0]                    setpoint,
  input  logic [S+F-1:0]                  p_gain,
  input  logic [S+F-1:0]                  i_gain,
  input  logic [S+F-1:0]                  d_gain,
  output logic                            vld,
  output logic signed [S:0]               err,
  output logic signed [2*S+F+1:0]         p_prod,
  output logic signed [2*S+F+1:0]         i_prod,
  output logic signed [2*S+F+2:0]         d_prod
);
  import pidaw_pkg::*;

  localparam int G  = S + F;
  localparam int E  = S + 1;
  localparam int D  = S + 2;
  localparam int PW = G + S + 2;
  localparam int DW = G + S + 3;

  logic                 v1_r;
  logic [S-1:0]         fb_r;
  logic                 v2_r;
  logic signed [E-1:0]  err_r;
  logic signed [E-1:0]  last_err_r;
  logic signed [PW-1:0] p_r;
  logic signed [PW-1:0] i_r;
  logic signed [DW-1:0] d_r;

  logic signed [E-1:0]  err_c;
  logic signed [D-1:0]  derr_c;

  assign err_c  = $signed({1'b0, setpoint}) - $signed({1'b0, fb_r});
  assign derr_c = $signed({err_c[E-1], err_c}) - $signed({last_err_r[E-1], last_err_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      last_err_r <= '0;
    end else if (ctl.adv) begin
      v1_r <= ctl.vld;
      v2_r <= v1_r;
      if (v1_r) last_err_r <= err_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      fb_r  <= feedback;
      err_r <= err_c;
      p_r   <= $signed({1'b0, p_gain}) * err_c;
      i_r   <= $signed({1'b0, i_gain}) * err_c;
      d_r   <= $signed({1'b0, d_gain}) * derr_c;
    end
  end

  assign vld    = v2_r;
  assign err    = err_r;
  assign p_prod = p_r;
  assign i_prod = i_r;
  assign d_prod = d_r;

endmodule

// ----- hdl/pidaw_integ.sv -----
// pidaw_integ: clamped integral accumulator and the P+D partial sum.
// Depends on pidaw_pkg.
module pidaw_integ #(
  parameter int S = 12,
  parameter int F = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pidaw_pkg::stage_ctl_t           ctl,
  input  logic signed [S:0]               err,
  input  logic signed [2*S+F+1:0]         p_prod,
  input  logic signed [2*S+F+1:0]         i_prod,
  input  logic signed [2*S+F+2:0]         d_prod,
  input  logic [S-1:0]                    drive_limit,
  output logic                            vld,
  output logic signed [S:0]               err_q,
  output logic [S+F-1:0]                  acc_q,
  output logic signed [2*S+F+4:0]         pd_q
);
  import pidaw_pkg::*;

  localparam int G  = S + F;
  localparam int E  = S + 1;
  localparam int SW = G + S + 5;

  logic                 v3_r;
  logic [G-1:0]         integ_r;
  logic [G-1:0]         integ_nxt;
  logic [G-1:0]         acc_r;
  logic signed [SW-1:0] pd_r;
  logic signed [E-1:0]  err_r;

  logic [G-1:0]         lim_q;
  logic signed [SW-1:0] acc_full;

  assign lim_q    = {drive_limit, {F{1'b0}}};
  assign acc_full = $signed({{(SW-G){1'b0}}, integ_r}) + SW'(i_prod);

  // anti-windup: hold the integral inside [0, drive_limit]
  always_comb begin
    if (acc_full > $signed({{(SW-G){1'b0}}, lim_q})) begin
      integ_nxt = lim_q;
    end else if (acc_full < 0) begin
      integ_nxt = '0;
    end else begin
      integ_nxt = acc_full[G-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r    <= 1'b0;
      integ_r <= '0;
    end else if (ctl.adv) begin
      v3_r <= ctl.vld;
      if (ctl.vld) integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      acc_r <= integ_nxt;
      pd_r  <= SW'(p_prod) + SW'(d_prod);
      err_r <= err;
    end
  end

  assign vld   = v3_r;
  assign err_q = err_r;
  assign acc_q = acc_r;
  assign pd_q  = pd_r;

endmodule

// ----- hdl/pidaw_clamp.sv -----
// pidaw_clamp: final sum, truncation and drive clamp into the result register.
// Depends on pidaw_pkg.
module pidaw_clamp #(
  parameter int S = 12,
  parameter int F = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pidaw_pkg::stage_ctl_t           ctl,
  input  logic signed [S:0]               err,
  input  logic [S+F-1:0]                  acc,
  input  logic signed [2*S+F+4:0]         pd,
  input  logic [S-1:0]                    drive_limit,
  output logic                            vld,
  output logic [S-1:0]                    drive,
  output logic signed [S:0]               error_value
);
  import pidaw_pkg::*;

  localparam int G  = S + F;
  localparam int E  = S + 1;
  localparam int SW = G + S + 5;
  localparam int QW = SW - F;

  logic                 vo_r;
  logic [S-1:0]         drive_r;
  logic [S-1:0]         drive_nxt;
  logic signed [E-1:0]  err_r;

  logic signed [SW-1:0] sum;
  logic [QW-1:0]        whole;

  assign sum   = pd + $signed({{(SW-G){1'b0}}, acc});
  assign whole = sum[SW-1:F];

  always_comb begin
    if (sum <= 0) begin
      drive_nxt = '0;
    end else if (whole > {{(QW-S){1'b0}}, drive_limit}) begin
      drive_nxt = drive_limit;
    end else begin
      drive_nxt = whole[S-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (ctl.adv) begin
      vo_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      drive_r <= drive_nxt;
      err_r   <= err;
    end
  end

  assign vld         = vo_r;
  assign drive       = drive_r;
  assign error_value = err_r;

endmodule

// ----- hdl/pid_drive_with_anti_windup_top.sv -----
// pid_drive_with_anti_windup_top: PID drive with clamped integral, top level.
// Depends on pidaw_pkg, pidaw_if, pidaw_cfg, pidaw_mult, pidaw_integ, pidaw_clamp.
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------
//   in_ch    | sink      | feedback [S-1:0]
//   out_ch   | source    | drive [S-1:0], error_value [S:0] signed
//   cfg_*    | write     | cfg_index selects register, cfg_data value
//
// One item per cycle unless a result is held; an accepted item passes every stage.
// Four registered stages (sample, products, integral, result) advance together;
// the integral update closes its loop inside the integral stage.
// A result held by out_ch.ready low stalls every stage and drops in_ch.ready.
// Reset (rst_n low, synchronous) empties the pipeline, zeros the integral and
// last error, and restores the register defaults.
module pid_drive_with_anti_windup_top #(
  parameter int SAMPLE_BITS    = 12,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  pidaw_in_if.sink                                     in_ch,
  pidaw_out_if.source                                  out_ch,
  input  logic                                         cfg_we,
  input  logic [pidaw_pkg::CFG_IDX_BITS-1:0]           cfg_index,
  input  logic [SAMPLE_BITS+GAIN_FRAC_BITS-1:0]        cfg_data
);
  import pidaw_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int F  = GAIN_FRAC_BITS;
  localparam int G  = S + F;
  localparam int PW = G + S + 2;
  localparam int DW = G + S + 3;
  localparam int SW = G + S + 5;

  logic [S-1:0] setpoint;
  logic [G-1:0] p_gain;
  logic [G-1:0] i_gain;
  logic [G-1:0] d_gain;
  logic [S-1:0] drive_limit;

  logic                 adv;
  logic                 v2;
  logic                 v3;
  logic                 vo;
  logic signed [S:0]    err2;
  logic signed [PW-1:0] p_prod;
  logic signed [PW-1:0] i_prod;
  logic signed [DW-1:0] d_prod;
  logic signed [S:0]    err3;
  logic [G-1:0]         acc3;
  logic signed [SW-1:0] pd3;

  stage_ctl_t ctl_mult;
  stage_ctl_t ctl_integ;
  stage_ctl_t ctl_clamp;

  // whole pipeline moves unless a finished result is waiting
  assign adv         = !vo || out_ch.ready;
  assign in_ch.ready = adv;

  assign ctl_mult  = '{adv: adv, vld: in_ch.valid};
  assign ctl_integ = '{adv: adv, vld: v2};
  assign ctl_clamp = '{adv: adv, vld: v3};

  pidaw_cfg #(.S(S), .F(F)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .setpoint    (setpoint),
    .p_gain      (p_gain),
    .i_gain      (i_gain),
    .d_gain      (d_gain),
    .drive_limit (drive_limit)
  );

  pidaw_mult #(.S(S), .F(F)) u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_mult),
    .feedback (in_ch.feedback),
    .setpoint (setpoint),
    .p_gain   (p_gain),
    .i_gain   (i_gain),
    .d_gain   (d_gain),
    .vld      (v2),
    .err      (err2),
    .p_prod   (p_prod),
    .i_prod   (i_prod),
    .d_prod   (d_prod)
  );

  pidaw_integ #(.S(S), .F(F)) u_integ (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl_integ),
    .err         (err2),
    .p_prod      (p_prod),
    .i_prod      (i_prod),
    .d_prod      (d_prod),
    .drive_limit (drive_limit),
    .vld         (v3),
    .err_q       (err3),
    .acc_q       (acc3),
    .pd_q        (pd3)
  );

  pidaw_clamp #(.S(S), .F(F)) u_clamp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl_clamp),
    .err         (err3),
    .acc         (acc3),
    .pd          (pd3),
    .drive_limit (drive_limit),
    .vld         (vo),
    .drive       (out_ch.drive),
    .error_value (out_ch.error_value)
  );

  assign out_ch.valid = vo;

endmodule

// ----- hdl/pidaw_checker.sv -----
// pidaw_port_checker: port-level assertions for the PID drive top level, and its bind.
// Depends on pid_drive_with_anti_windup_top and pidaw_if.
module pidaw_port_checker #(
  parameter int S = 12
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [S-1:0]        drive,
  input logic signed [S:0]   error_value
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(error_value))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // with no result pending the block must take items
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // error of two S-bit unsigned values never reaches the most negative code
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(error_value[S] && (error_value[S-1:0] == '0)))
    else $error("error_value out of range");

  // an accepted item shows up as a result if out_ready keeps the pipeline moving
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind pid_drive_with_anti_windup_top pidaw_port_checker #(.S(SAMPLE_BITS)) u_pidaw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .drive       (out_ch.drive),
  .error_value (out_ch.error_value)
);

// ----- tb/pidaw_checker.sv -----
// pidaw_checker: predicts drive and error for every accepted feedback item and
// compares each accepted result against the oldest prediction.
// Depends on pidaw_pkg and the pidaw_in_if / pidaw_out_if channels.
module pidaw_checker
  import pidaw_pkg::*;
#(
  parameter int SAMPLE_BITS    = 12,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  pidaw_in_if                                   in_ch,
  pidaw_out_if                                  out_ch,
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_BITS-1:0]               cfg_index,
  input  logic [SAMPLE_BITS+GAIN_FRAC_BITS-1:0] cfg_data,
  output int                                    mismatch_cnt,
  output int                                    pending_cnt
);

  typedef struct {
    logic [SAMPLE_BITS-1:0]      drive;
    logic signed [SAMPLE_BITS:0] error_value;
  } pid_result_t;

  pid_result_t result_q[$];
  pid_result_t want;
  int          result_idx;

  // Register shadows
  logic [SAMPLE_BITS-1:0]                setpoint_r;
  logic [SAMPLE_BITS-1:0]                limit_r;
  logic [SAMPLE_BITS+GAIN_FRAC_BITS-1:0] kp_r;
  logic [SAMPLE_BITS+GAIN_FRAC_BITS-1:0] ki_r;
  logic [SAMPLE_BITS+GAIN_FRAC_BITS-1:0] kd_r;

  // Controller state; integral kept in Q.F
  longint integ_acc;
  longint prev_err;

  initial begin
    mismatch_cnt = 0;
    pending_cnt  = 0;
    result_idx   = 0;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch on result %0d: %s", $time, result_idx, what);
    mismatch_cnt++;
  endtask

  function automatic pid_result_t pid_step(input logic [SAMPLE_BITS-1:0] fb);
    longint      err;
    longint      lim_q;
    longint      p_term;
    longint      d_term;
    longint      acc;
    longint      sum;
    longint      drv;
    pid_result_t r;
    err    = longint'(setpoint_r) - longint'(fb);
    lim_q  = longint'(limit_r) <<< GAIN_FRAC_BITS;
    p_term = longint'(kp_r) * err;
    d_term = longint'(kd_r) * (err - prev_err);
    acc    = integ_acc + longint'(ki_r) * err;
    if (acc > lim_q) acc = lim_q;
    else if (acc < 0) acc = 0;
    integ_acc = acc;
    prev_err  = err;
    sum = p_term + acc + d_term;
    if (sum <= 0) begin
      drv = 0;
    end else begin
      drv = sum >>> GAIN_FRAC_BITS;
      if (drv > longint'(limit_r)) drv = longint'(limit_r);
    end
    r.drive       = drv[SAMPLE_BITS-1:0];
    r.error_value = err[SAMPLE_BITS:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r = RST_SETPOINT[SAMPLE_BITS-1:0];
      kp_r       = RST_P_GAIN[SAMPLE_BITS+GAIN_FRAC_BITS-1:0];
      ki_r       = RST_I_GAIN[SAMPLE_BITS+GAIN_FRAC_BITS-1:0];
      kd_r       = RST_D_GAIN[SAMPLE_BITS+GAIN_FRAC_BITS-1:0];
      limit_r    = RST_DRIVE_LIMIT[SAMPLE_BITS-1:0];
      integ_acc  = 0;
      prev_err   = 0;
      result_q.delete();
    end else begin
      // narrow registers keep only their low bits; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_SETPOINT:    setpoint_r = cfg_data[SAMPLE_BITS-1:0];
          CFG_P_GAIN:      kp_r = cfg_data;
          CFG_I_GAIN:      ki_r = cfg_data;
          CFG_D_GAIN:      kd_r = cfg_data;
          CFG_DRIVE_LIMIT: limit_r = cfg_data[SAMPLE_BITS-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected item drive %0d error %0d",
                                  out_ch.drive, out_ch.error_value));
        end else begin
          want = result_q.pop_front();
          if (out_ch.drive !== want.drive)
            flag_mismatch($sformatf("drive got %0d want %0d", out_ch.drive, want.drive));
          if (out_ch.error_value !== want.error_value)
            flag_mismatch($sformatf("error_value got %0d want %0d",
                                    out_ch.error_value, want.error_value));
        end
        result_idx++;
      end
      if (in_ch.valid && in_ch.ready)
        result_q.push_back(pid_step(in_ch.feedback));
    end
    pending_cnt <= result_q.size();
  end

endmodule

// ----- tb/pid_drive_with_anti_windup_top_test.sv -----
// pid_drive_with_anti_windup_top_test: drives feedback items and register
// writes into the PID drive block with random stalls on both channels.
// Depends on pidaw_pkg, pidaw_if, the block's RTL and pidaw_checker.
module pid_drive_with_anti_windup_top_test;
  import pidaw_pkg::*;

  localparam int S = 12;
  localparam int F = 8;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [S+F-1:0]          cfg_data;
  int                      mismatch_cnt;
  int                      pending_cnt;

  logic [S-1:0] sp_now;
  bit           in_fast;
  bit           out_fast;
  bit           first_phase;
  int           sent;
  int           burst_len;

  pidaw_in_if  #(.SAMPLE_BITS(S)) in_ch ();
  pidaw_out_if #(.SAMPLE_BITS(S)) out_ch ();

  pid_drive_with_anti_windup_top #(
    .SAMPLE_BITS   (S),
    .GAIN_FRAC_BITS(F)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pidaw_checker #(
    .SAMPLE_BITS   (S),
    .GAIN_FRAC_BITS(F)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatch_cnt(mismatch_cnt),
    .pending_cnt (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [S+F-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SETPOINT) sp_now = val[S-1:0];
  endtask

  task automatic push_sample(input logic [S-1:0] fb);
    int gap;
    if ($urandom_range(0, 39) == 0) in_fast = !in_fast;
    gap = in_fast ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.feedback <= fb;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sent++;
  endtask

  // pending_cnt is registered, so step past the last accept before polling it
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  function automatic logic [S-1:0] pick_feedback();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = (1 << S) - 1;
      2, 3, 4, 5: begin
        v = int'(sp_now) + int'($urandom_range(0, 32)) - 16;
        if (v < 0) v = 0;
        if (v > (1 << S) - 1) v = (1 << S) - 1;
      end
      default: v = $urandom_range(0, (1 << S) - 1);
    endcase
    return v[S-1:0];
  endfunction

  // full-width draws also exercise masking of the narrow registers
  function automatic logic [S+F-1:0] pick_reg_value(input logic [CFG_IDX_BITS-1:0] idx);
    int sel;
    sel = $urandom_range(0, 7);
    if (idx == CFG_SETPOINT || idx == CFG_DRIVE_LIMIT) begin
      case (sel)
        0:       return '0;
        1:       return '1;
        2, 3, 4: return (S+F)'($urandom_range(0, (1 << S) - 1));
        default: return (S+F)'($urandom);
      endcase
    end
    case (sel)
      0:       return '0;
      1:       return '1;
      2, 3, 4: return (S+F)'($urandom_range(0, 1023));
      5:       return (S+F)'($urandom_range(0, 4095));
      default: return (S+F)'($urandom);
    endcase
  endfunction

  initial begin
    int wait_cycles;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) out_fast = !out_fast;
      wait_cycles = out_fast ? 0 : $urandom_range(0, 16);
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_SETPOINT;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.feedback <= '0;
    sp_now      = RST_SETPOINT[S-1:0];
    in_fast     = 1'b0;
    out_fast    = 1'b0;
    first_phase = 1'b1;
    sent        = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: feedback at both extremes, then zero error
    push_sample('0);
    push_sample('1);
    push_sample(sp_now);
    push_sample(sp_now);
    repeat (3) push_sample('0);
    drain();

    // every register at its maximum: integral saturates at once, big D swings
    write_reg(CFG_SETPOINT, '1);
    write_reg(CFG_P_GAIN, '1);
    write_reg(CFG_I_GAIN, '1);
    write_reg(CFG_D_GAIN, '1);
    write_reg(CFG_DRIVE_LIMIT, '1);
    push_sample('0);
    push_sample('0);
    push_sample('1);
    push_sample('0);
    push_sample('1);
    drain();

    // zero limit pins drive and integral to zero
    write_reg(CFG_DRIVE_LIMIT, '0);
    push_sample('0);
    push_sample('1);
    push_sample(12'd100);
    drain();

    // writes to unmapped indexes must leave every register alone
    for (int k = int'(CFG_DRIVE_LIMIT) + 1; k < (1 << CFG_IDX_BITS); k++)
      write_reg(k[CFG_IDX_BITS-1:0], '1);

    // negative error drives the sum below zero
    write_reg(CFG_SETPOINT, '0);
    write_reg(CFG_P_GAIN, 20'd256);
    write_reg(CFG_I_GAIN, '0);
    write_reg(CFG_D_GAIN, '0);
    write_reg(CFG_DRIVE_LIMIT, '1);
    push_sample('1);
    push_sample('0);
    push_sample('1);
    drain();

    while (sent < 1000) begin
      for (int k = int'(CFG_SETPOINT); k <= int'(CFG_DRIVE_LIMIT); k++) begin
        if (first_phase || $urandom_range(0, 1) == 1)
          write_reg(k[CFG_IDX_BITS-1:0], pick_reg_value(k[CFG_IDX_BITS-1:0]));
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_BITS'($urandom_range(int'(CFG_DRIVE_LIMIT) + 1,
                                               (1 << CFG_IDX_BITS) - 1)),
                  (S+F)'($urandom));
      first_phase = 1'b0;
      burst_len = $urandom_range(40, 150);
      repeat (burst_len) push_sample(pick_feedback());
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
